// ----- src/mcfp_pkg.sv -----
// shared types and constants for the pose frame parser
`timescale 1ns / 1ps
package mcfp_pkg;

  // frame layout
  localparam int FRAME_LEN = 21;
  localparam int LAST_POS  = FRAME_LEN - 1;
  localparam int BUF_LEN   = FRAME_LEN - 1;
  localparam int IDX_W     = 5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LAST_POS);

  // byte positions inside a frame
  localparam int POS_BEGIN = 0;
  localparam int POS_ID    = 1;
  localparam int POS_X     = 2;
  localparam int POS_Y     = 5;
  localparam int POS_Z     = 8;
  localparam int POS_ROLL  = 11;
  localparam int POS_PITCH = 14;
  localparam int POS_YAW   = 17;

  // sign characters
  localparam logic [7:0] SIGN_PLUS  = 8'h2B;
  localparam logic [7:0] SIGN_MINUS = 8'h2D;

  // input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_STATION_ID  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BEGIN_CODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_CODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_THRESH = 3'd5;

  // configuration reset values
  localparam logic [7:0]  RST_STATION_ID  = 8'h00;
  localparam logic [7:0]  RST_BEGIN_CODE  = 8'd36;
  localparam logic [7:0]  RST_END_CODE    = 8'd35;
  localparam logic [15:0] RST_TRANS_LIMIT = 16'd3500;
  localparam logic [15:0] RST_YAW_LIMIT   = 16'd18000;
  localparam logic [7:0]  RST_LINK_THRESH = 8'd25;

  // link supervision
  localparam logic [1:0] MISS_MAX   = 2'd3;
  localparam logic [1:0] MISS_LIMIT = 2'd1;
  localparam logic [7:0] GOOD_MAX   = 8'd255;

  typedef enum logic [2:0] {
    KIND_POSE       = 3'd0,
    KIND_BAD_FORMAT = 3'd1,
    KIND_RANGE      = 3'd2,
    KIND_STATION    = 3'd3,
    KIND_LINK       = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0]  station_id;
    logic [7:0]  begin_code;
    logic [7:0]  end_code;
    logic [15:0] translation_limit;
    logic [15:0] yaw_limit;
    logic [7:0]  link_threshold;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] yaw_val;
    logic signed [15:0] pitch_val;
    logic signed [15:0] roll_val;
    logic signed [16:0] pos_z;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_x;
  } pose_t;

  typedef struct packed {
    kind_t kind;
    pose_t pose;
  } judge_t;

  typedef logic [BUF_LEN-1:0][7:0] frame_buf_t;

endpackage

// ----- src/motion_capture_frame_parser.sv -----
// top level of the pose frame parser: input register, link status, result register
`timescale 1ns / 1ps
// an accepted transaction passes through the input register and then the result register
// throughput: one input transaction per cycle; a result waiting on m_axis stalls s_axis
// a byte completes a frame, or a tick reports, with one result; other bytes give none
// rst (synchronous) clears the pipeline, frame position, counters, link flag and
// loads the configuration defaults; no clearing pass is needed
module motion_capture_frame_parser import mcfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // rx_byte[7:0]
  input  logic                  s_axis_tuser,  // opcode
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pos_x[16:0], pos_y[33:17], pos_z[50:34], roll_val[66:51], pitch_val[82:67],
  // yaw_val[98:83], link_up[99], good_frames[107:100], zero fill[111:108]
  output logic [111:0]          m_axis_tdata,
  output logic [2:0]            m_axis_tuser   // result_kind
);

  cfg_t       cfg;
  logic       in_valid;
  logic       in_op;
  logic [7:0] in_byte;
  logic       advance;
  logic       byte_en;
  logic       tick;
  logic       frame_done;
  frame_buf_t frame_buf;
  judge_t     judge;

  logic [7:0] good_count;
  logic [7:0] good_count_next;
  logic [1:0] miss_count;
  logic [1:0] miss_count_next;
  logic       link_flag;
  logic       link_flag_next;

  logic       out_valid;
  kind_t      out_kind;
  pose_t      out_pose;
  logic       out_link;
  logic [7:0] out_good;
  logic       emit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.station_id        <= RST_STATION_ID;
      cfg.begin_code        <= RST_BEGIN_CODE;
      cfg.end_code          <= RST_END_CODE;
      cfg.translation_limit <= RST_TRANS_LIMIT;
      cfg.yaw_limit         <= RST_YAW_LIMIT;
      cfg.link_threshold    <= RST_LINK_THRESH;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_STATION_ID:  cfg.station_id        <= cfg_data[7:0];
        REG_BEGIN_CODE:  cfg.begin_code        <= cfg_data[7:0];
        REG_END_CODE:    cfg.end_code          <= cfg_data[7:0];
        REG_TRANS_LIMIT: cfg.translation_limit <= cfg_data;
        REG_YAW_LIMIT:   cfg.yaw_limit         <= cfg_data;
        REG_LINK_THRESH: cfg.link_threshold    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign byte_en       = advance && (in_op == OP_BYTE);
  assign tick          = advance && (in_op == OP_TICK);
  assign emit          = tick || frame_done;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  mcfp_assembler u_assembler (
    .clk        (clk),
    .rst        (rst),
    .byte_en    (byte_en),
    .rx_byte    (in_byte),
    .cfg        (cfg),
    .frame_done (frame_done),
    .frame_buf  (frame_buf)
  );

  mcfp_judge u_judge (
    .frame_buf (frame_buf),
    .cfg       (cfg),
    .judge     (judge)
  );

  // good frame count and link supervision
  always_comb begin
    good_count_next = good_count;
    miss_count_next = miss_count;
    link_flag_next  = link_flag;
    if (tick) begin
      good_count_next = '0;
      if (good_count > cfg.link_threshold) begin
        link_flag_next  = 1'b1;
        miss_count_next = '0;
      end else if (miss_count < MISS_MAX) begin
        miss_count_next = miss_count + 2'd1;
      end
      if (miss_count_next > MISS_LIMIT) begin
        link_flag_next = 1'b0;
      end
    end else if (frame_done && judge.kind == KIND_POSE && good_count != GOOD_MAX) begin
      good_count_next = good_count + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      good_count <= '0;
      miss_count <= '0;
      link_flag  <= 1'b0;
    end else begin
      good_count <= good_count_next;
      miss_count <= miss_count_next;
      link_flag  <= link_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (tick) begin
        out_kind <= KIND_LINK;
        out_pose <= '0;
        out_link <= link_flag_next;
        out_good <= good_count;
      end else begin
        out_kind <= judge.kind;
        out_pose <= judge.pose;
        out_link <= link_flag;
        out_good <= good_count_next;
      end
    end
  end

  // result packing
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {4'd0, out_good, out_link, out_pose};

endmodule

// ----- src/mcfp_assembler.sv -----
// frame byte collection: position counter, in-frame flag and byte buffer
`timescale 1ns / 1ps
module mcfp_assembler import mcfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_en,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output logic       frame_done,
  output frame_buf_t frame_buf
);

  logic [IDX_W-1:0] byte_index;
  logic [IDX_W-1:0] byte_index_next;
  logic             in_frame;
  logic             in_frame_next;
  logic             start;
  logic             at_last;

  assign at_last    = (byte_index == LAST_IDX);
  assign start      = byte_en && !in_frame && (rx_byte == cfg.begin_code);
  assign frame_done = byte_en && in_frame && at_last && (rx_byte == cfg.end_code);

  // position and frame tracking
  always_comb begin
    byte_index_next = byte_index;
    in_frame_next   = in_frame;
    if (byte_en) begin
      if (start) begin
        in_frame_next   = 1'b1;
        byte_index_next = IDX_W'(1);
      end else if (at_last) begin
        // frame completes, or the run hits frame length: start over
        in_frame_next   = 1'b0;
        byte_index_next = '0;
      end else begin
        byte_index_next = byte_index + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
      in_frame   <= 1'b0;
    end else begin
      byte_index <= byte_index_next;
      in_frame   <= in_frame_next;
    end
  end

  // byte buffer, last position is never stored (it is the end byte itself)
  always_ff @(posedge clk) begin
    for (int i = 0; i < BUF_LEN; i++) begin
      if (byte_en && ((byte_index == IDX_W'(i)) || (i == POS_BEGIN && start))) begin
        frame_buf[i] <= rx_byte;
      end
    end
  end

endmodule

// ----- src/mcfp_judge.sv -----
// frame classification and pose decode
`timescale 1ns / 1ps
module mcfp_judge import mcfp_pkg::*; (
  input  frame_buf_t frame_buf,
  input  cfg_t       cfg,
  output judge_t     judge
);

  logic        signs_ok;
  logic        id_ok;
  logic        format_ok;
  logic        range_ok;
  logic [15:0] mag_x;
  logic [15:0] mag_y;
  logic [15:0] mag_z;
  logic [15:0] mag_roll;
  logic [15:0] mag_pitch;
  logic [15:0] mag_yaw;

  function automatic logic sign_valid(input logic [7:0] s);
    sign_valid = (s == SIGN_PLUS) || (s == SIGN_MINUS);
  endfunction

  function automatic logic [16:0] apply_sign17(input logic [7:0] s, input logic [15:0] m);
    logic [16:0] wide;
    wide = {1'b0, m};
    apply_sign17 = (s == SIGN_MINUS) ? (17'd0 - wide) : wide;
  endfunction

  function automatic logic [15:0] apply_sign16(input logic [7:0] s, input logic [15:0] m);
    apply_sign16 = (s == SIGN_MINUS) ? (16'd0 - m) : m;
  endfunction

  // big-endian magnitudes
  assign mag_x     = {frame_buf[POS_X+1],     frame_buf[POS_X+2]};
  assign mag_y     = {frame_buf[POS_Y+1],     frame_buf[POS_Y+2]};
  assign mag_z     = {frame_buf[POS_Z+1],     frame_buf[POS_Z+2]};
  assign mag_roll  = {frame_buf[POS_ROLL+1],  frame_buf[POS_ROLL+2]};
  assign mag_pitch = {frame_buf[POS_PITCH+1], frame_buf[POS_PITCH+2]};
  assign mag_yaw   = {frame_buf[POS_YAW+1],   frame_buf[POS_YAW+2]};

  // format checks, the end byte already matched when the frame completed
  assign signs_ok = sign_valid(frame_buf[POS_X])    && sign_valid(frame_buf[POS_Y])
                 && sign_valid(frame_buf[POS_Z])    && sign_valid(frame_buf[POS_ROLL])
                 && sign_valid(frame_buf[POS_PITCH]) && sign_valid(frame_buf[POS_YAW]);
  assign id_ok     = (frame_buf[POS_ID] == cfg.station_id);
  assign format_ok = id_ok && (frame_buf[POS_BEGIN] == cfg.begin_code) && signs_ok;
  assign range_ok  = (mag_x <= cfg.translation_limit) && (mag_y <= cfg.translation_limit)
                  && (mag_z <= cfg.translation_limit) && (mag_yaw <= cfg.yaw_limit);

  // classify and fill pose only for an accepted frame
  always_comb begin
    judge = '0;
    if (format_ok && range_ok) begin
      judge.kind            = KIND_POSE;
      judge.pose.pos_x      = apply_sign17(frame_buf[POS_X], mag_x);
      judge.pose.pos_y      = apply_sign17(frame_buf[POS_Y], mag_y);
      judge.pose.pos_z      = apply_sign17(frame_buf[POS_Z], mag_z);
      judge.pose.roll_val   = apply_sign16(frame_buf[POS_ROLL], mag_roll);
      judge.pose.pitch_val  = apply_sign16(frame_buf[POS_PITCH], mag_pitch);
      judge.pose.yaw_val    = apply_sign16(frame_buf[POS_YAW], mag_yaw);
    end else if (format_ok) begin
      judge.kind = KIND_RANGE;
    end else if (!id_ok) begin
      judge.kind = KIND_STATION;
    end else begin
      judge.kind = KIND_BAD_FORMAT;
    end
  end

endmodule
